FILE: hw/rtl/lsuw_pkg.sv
// Package for the load/store unit with MMIO windows.
// Holds sizes, codes, item structs and the helpers shared by all modules.
// No dependencies.
package lsuw_pkg;

  localparam int RAM_BYTES    = 65536;
  localparam int MMIO_WINDOWS = 2;

  // RAM is kept as eight byte lanes, one row of eight bytes per lane address
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int ROWS   = (RAM_BYTES + LANES - 1) / LANES;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int MEM_SIZE_W = 17;
  localparam int LIM_W      = (RAM_BYTES > 65536) ? $clog2(RAM_BYTES) + 1 : MEM_SIZE_W;
  localparam logic [MEM_SIZE_W-1:0] MEM_SIZE_RST = 17'h10000;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN0_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN0_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN1_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN1_LEN  = 3'd4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  // width codes
  localparam logic [3:0] WC_SB = 4'h0;
  localparam logic [3:0] WC_SH = 4'h1;
  localparam logic [3:0] WC_SW = 4'h2;
  localparam logic [3:0] WC_SD = 4'h3;
  localparam logic [3:0] WC_UB = 4'h4;
  localparam logic [3:0] WC_UH = 4'h5;
  localparam logic [3:0] WC_UW = 4'h6;

  localparam logic [1:0] FAULT_OK      = 2'd0;
  localparam logic [1:0] FAULT_ILLEGAL = 2'd1;
  localparam logic [1:0] FAULT_RANGE   = 2'd2;

  localparam logic [1:0] LG_B = 2'd0;
  localparam logic [1:0] LG_H = 2'd1;
  localparam logic [1:0] LG_W = 2'd2;
  localparam logic [1:0] LG_D = 2'd3;

  localparam logic [3:0] REG_PC = 4'hF;

  typedef struct packed {
    logic               func;
    logic [3:0]         width_code;
    logic [63:0]        base_value;
    logic signed [63:0] offset;
    logic [3:0]         dest_reg;
    logic [63:0]        store_data;
  } req_t;

  typedef struct packed {
    logic [1:0]  fault;
    logic        reg_write;
    logic [3:0]  write_reg;
    logic [63:0] load_value;
    logic        advance_pc;
    logic        mmio_hit;
    logic        mmio_window;
    logic [63:0] mmio_addr;
    logic [3:0]  mmio_bytes;
    logic        mmio_is_write;
    logic [63:0] mmio_data;
  } rsp_t;

  // classified operation handed from the front end to the back end
  typedef struct packed {
    logic [1:0]  fault;
    logic        mmio_hit;
    logic        mmio_window;
    logic        is_store;
    logic        sign;
    logic [1:0]  lg;
    logic [3:0]  dest_reg;
    logic [63:0] addr;
    logic [63:0] data;
  } op_t;

  typedef enum logic {
    BK_CLEAR,
    BK_RUN
  } bk_state_t;

  function automatic logic [3:0] size_bytes(input logic [1:0] lg);
    return 4'd1 << lg;
  endfunction

endpackage

FILE: hw/rtl/lsuw_front.sv
// Front end: configuration registers, address add and classification.
// Depends on lsuw_pkg.
module lsuw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  lsuw_pkg::req_t                 req,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsuw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           push,
  output lsuw_pkg::op_t                  push_op
);
  import lsuw_pkg::*;

  logic [MEM_SIZE_W-1:0] mem_size;
  logic [63:0]           win0_base;
  logic [63:0]           win0_len;
  logic [63:0]           win1_base;
  logic [63:0]           win1_len;

  logic        s1_valid;
  req_t        s1_req;
  logic [63:0] s1_addr;

  logic             accept;
  logic             is_store;
  logic             legal;
  logic [1:0]       lg;
  logic [3:0]       nbytes;
  logic             hit0;
  logic             hit1;
  logic [LIM_W-1:0] ms_ext;
  logic [LIM_W-1:0] limit;
  logic [LIM_W:0]   addr_end;
  logic             over;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size  <= MEM_SIZE_RST;
      win0_base <= '0;
      win0_len  <= '0;
      win1_base <= '0;
      win1_len  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MEM_SIZE:  mem_size  <= cfg_data[MEM_SIZE_W-1:0];
        CFG_WIN0_BASE: win0_base <= cfg_data;
        CFG_WIN0_LEN:  win0_len  <= cfg_data;
        CFG_WIN1_BASE: win1_base <= cfg_data;
        CFG_WIN1_LEN:  win1_len  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign push      = s1_valid && !q_full;
  assign req_ready = !clearing && (!s1_valid || !q_full);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req  <= req;
      s1_addr <= req.base_value + $unsigned(req.offset);
    end
  end

  always_comb begin
    is_store = (s1_req.func == FUNC_STORE);
    legal    = (s1_req.width_code <= WC_UW) && !(is_store && s1_req.width_code > WC_SD);
    lg       = s1_req.width_code[1:0];
    nbytes   = size_bytes(lg);
    // window match is a wrapping distance from the base
    hit0     = (s1_addr - win0_base) < win0_len;
    hit1     = (MMIO_WINDOWS > 1) && ((s1_addr - win1_base) < win1_len);
    ms_ext   = LIM_W'(mem_size);
    limit    = (ms_ext < LIM_W'(RAM_BYTES)) ? ms_ext : LIM_W'(RAM_BYTES);
    // end of access without wrapping
    addr_end = {1'b0, s1_addr[LIM_W-1:0]} + (LIM_W+1)'(nbytes);
    over     = (|s1_addr[63:LIM_W]) || (addr_end > {1'b0, limit});

    push_op.fault       = FAULT_OK;
    push_op.mmio_hit    = 1'b0;
    push_op.mmio_window = 1'b0;
    push_op.is_store    = is_store;
    push_op.sign        = !s1_req.width_code[2];
    push_op.lg          = lg;
    push_op.dest_reg    = s1_req.dest_reg;
    push_op.addr        = s1_addr;
    push_op.data        = s1_req.store_data;
    priority if (!legal) begin
      push_op.fault = FAULT_ILLEGAL;
    end else if (hit0 || hit1) begin
      push_op.mmio_hit    = 1'b1;
      push_op.mmio_window = !hit0;
    end else if (over) begin
      push_op.fault = FAULT_RANGE;
    end else begin
      push_op.fault = FAULT_OK;
    end
  end

endmodule

FILE: hw/rtl/lsuw_queue.sv
// Short queue of classified operations between front and back end.
// Depends on lsuw_pkg.
module lsuw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lsuw_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lsuw_pkg::op_t head
);
  import lsuw_pkg::*;

  op_t               entry [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;

  assign full       = (cnt == QCNT_W'(QDEPTH));
  assign head_valid = (cnt != '0);
  assign head       = entry[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == QPTR_W'(QDEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == QPTR_W'(QDEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/lsuw_back.sv
// Back end: byte-lane RAM with clearing pass, load extension, result register.
// Depends on lsuw_pkg.
module lsuw_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lsuw_pkg::op_t  head,
  output logic           pop,
  output logic           clearing,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lsuw_pkg::rsp_t rsp
);
  import lsuw_pkg::*;

  bk_state_t state;
  bk_state_t state_next;

  logic [ROW_W-1:0] clr_row;

  logic [7:0] mem [LANES][ROWS];
  logic [7:0] rdata [LANES];

  logic              head_ram;
  logic [LANE_W-1:0] lane0;
  logic [ROW_W-1:0]  row0;
  logic [ROW_W-1:0]  row1;
  logic [LANE_W-1:0] off [LANES];
  logic [ROW_W-1:0]  lrow [LANES];
  logic              lane_en [LANES];
  logic [7:0]        wbyte [LANES];

  logic  b1_valid;
  op_t   b1_op;
  logic  b1_move;
  logic [63:0] raw;
  logic [63:0] ext;
  rsp_t  rsp_next;

  // clearing pass over all rows after reset
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: if (clr_row == ROW_W'(ROWS - 1)) state_next = BK_RUN;
      BK_RUN:   state_next = BK_RUN;
      default:  state_next = BK_CLEAR;
    endcase
  end

  always_comb begin
    clearing = (state == BK_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  assign b1_move = b1_valid && (!rsp_valid || rsp_ready);
  assign pop     = head_valid && !clearing && (!b1_valid || b1_move);

  always_comb begin
    head_ram = (head.fault == FAULT_OK) && !head.mmio_hit;
    lane0    = head.addr[LANE_W-1:0];
    row0     = ROW_W'(head.addr >> LANE_W);
    row1     = row0 + 1'b1;
    for (int k = 0; k < LANES; k++) begin
      off[k]     = LANE_W'(k) - lane0;
      lrow[k]    = (LANE_W'(k) >= lane0) ? row0 : row1;
      lane_en[k] = {1'b0, off[k]} < size_bytes(head.lg);
      wbyte[k]   = head.data[8*off[k] +: 8];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (clearing) begin
        mem[k][clr_row] <= 8'h00;
      end else if (pop && head_ram && head.is_store && lane_en[k]) begin
        mem[k][lrow[k]] <= wbyte[k];
      end
      if (pop && head_ram && !head.is_store) begin
        rdata[k] <= mem[k][lrow[k]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (pop) begin
      b1_valid <= 1'b1;
    end else if (b1_move) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_op <= head;
    end
  end

  // rotate lanes back to byte order, then extend
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      raw[8*i +: 8] = rdata[LANE_W'(i) + b1_op.addr[LANE_W-1:0]];
    end
    unique case (b1_op.lg)
      LG_B:    ext = {{56{b1_op.sign & raw[7]}}, raw[7:0]};
      LG_H:    ext = {{48{b1_op.sign & raw[15]}}, raw[15:0]};
      LG_W:    ext = {{32{b1_op.sign & raw[31]}}, raw[31:0]};
      LG_D:    ext = raw;
      default: ext = raw;
    endcase
  end

  always_comb begin
    rsp_next = '0;
    priority if (b1_op.fault != FAULT_OK) begin
      rsp_next.fault = b1_op.fault;
    end else if (b1_op.mmio_hit) begin
      rsp_next.advance_pc    = 1'b1;
      rsp_next.mmio_hit      = 1'b1;
      rsp_next.mmio_window   = b1_op.mmio_window;
      rsp_next.mmio_addr     = b1_op.addr;
      rsp_next.mmio_bytes    = size_bytes(b1_op.lg);
      rsp_next.mmio_is_write = b1_op.is_store;
      rsp_next.mmio_data     = b1_op.is_store ? b1_op.data : 64'd0;
    end else begin
      rsp_next.advance_pc = 1'b1;
      if (!b1_op.is_store) begin
        rsp_next.load_value = ext;
        if (b1_op.dest_reg != REG_PC) begin
          rsp_next.reg_write = 1'b1;
          rsp_next.write_reg = b1_op.dest_reg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (b1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: hw/rtl/load_store_unit_with_mmio_windows_core.sv
// Top level of the load/store unit with two MMIO windows.
// Depends on lsuw_pkg, lsuw_front, lsuw_queue, lsuw_back.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+-----------
//   req     | req_valid, req_ready, req (req_t)         | in
//   rsp     | rsp_valid, rsp_ready, rsp (rsp_t)         | out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One item per cycle sustained while rsp_ready stays high; rsp_valid follows accept
// through the address register, then queue, RAM read stage and result register.
// After reset a clearing pass zeroes the RAM, one row of eight bytes a
// cycle; req_ready stays low meanwhile, cfg stays open.
// A stalled rsp backs up the result register, the RAM stage, the two-entry
// queue and the address stage, five items in all, before req_ready drops.
// cfg_ready is always high.
module load_store_unit_with_mmio_windows_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  lsuw_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output lsuw_pkg::rsp_t                 rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsuw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                    cfg_data
);
  import lsuw_pkg::*;

  logic clearing;
  logic q_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic head_valid;
  op_t  head;

  lsuw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  lsuw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  lsuw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

endmodule

FILE: hw/rtl/lsuw_checker.sv
// Port-level checks for the load/store unit, bound to the top level.
// Depends on lsuw_pkg and load_store_unit_with_mmio_windows_core.
module lsuw_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input lsuw_pkg::rsp_t rsp
);
  import lsuw_pkg::*;

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fault != FAULT_OK |->
      !rsp.advance_pc && !rsp.reg_write && !rsp.mmio_hit)
    else $error("faulting item has side effects");

  a_mmio_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.mmio_hit |-> rsp.advance_pc && !rsp.reg_write &&
      (rsp.mmio_bytes == 4'd1 || rsp.mmio_bytes == 4'd2 ||
       rsp.mmio_bytes == 4'd4 || rsp.mmio_bytes == 4'd8))
    else $error("malformed MMIO request");

  a_no_pc_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.reg_write |-> rsp.write_reg != REG_PC && rsp.advance_pc)
    else $error("register write to PC");

endmodule

bind load_store_unit_with_mmio_windows_core lsuw_checker u_lsuw_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
